// ----- rtl/core/rcb_pkg.sv -----
// ----------------------------------------------------------------------------
// RGBA colour blend package
// Shared widths, operation codes, lane controls and the item types of the
// blend unit.
// ----------------------------------------------------------------------------
package rcb_pkg;

	localparam int FRAC_BITS = 8;
	localparam int CH_W      = 9;
	localparam int ALPHA_W   = 10;
	localparam int ACT_W     = 3;
	localparam int SUM_W     = CH_W + 1;
	localparam int PROD_W    = 2 * CH_W;
	localparam int SHP_W     = PROD_W - FRAC_BITS;
	localparam int MUL_W     = 2 * SHP_W;
	localparam int VAL_W     = MUL_W - FRAC_BITS;

	localparam logic [CH_W-1:0] ONE = CH_W'(1 << FRAC_BITS);

	localparam int NUM_LANES  = 4;
	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;
	localparam int LANE_ALPHA = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_AVERAGE  = 3'd0,
		ACT_ADD      = 3'd1,
		ACT_MULTIPLY = 3'd2,
		ACT_FILTER   = 3'd3,
		ACT_MIX      = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		LANE_ZERO,
		LANE_HALF,
		LANE_SUM,
		LANE_PSUM,
		LANE_PPROD,
		LANE_FADD,
		LANE_FSUB
	} lane_mode_t;

	typedef struct packed {
		lane_mode_t mode;
		logic       clamp;
	} lane_ctl_t;

	typedef struct packed {
		lane_ctl_t       ctl;
		logic [CH_W-1:0] x0;
		logic [CH_W-1:0] y0;
		logic [CH_W-1:0] x1;
		logic [CH_W-1:0] y1;
	} lane_op_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [CH_W-1:0]  a_red;
		logic [CH_W-1:0]  a_green;
		logic [CH_W-1:0]  a_blue;
		logic [CH_W-1:0]  a_alpha;
		logic [CH_W-1:0]  b_red;
		logic [CH_W-1:0]  b_green;
		logic [CH_W-1:0]  b_blue;
		logic [CH_W-1:0]  b_alpha;
		logic [CH_W-1:0]  mix_amount;
	} request_t;

	typedef struct packed {
		logic [CH_W-1:0]    out_red;
		logic [CH_W-1:0]    out_green;
		logic [CH_W-1:0]    out_blue;
		logic [ALPHA_W-1:0] out_alpha;
	} result_t;

endpackage

// ----- rtl/core/rcb_front.sv -----
// ----------------------------------------------------------------------------
// RGBA colour blend front stage
// Decodes the operation and registers the multiplier operands and controls
// of the three colour lanes and the alpha lane.
// ----------------------------------------------------------------------------
module rcb_front import rcb_pkg::*; (
	input  logic                            clk,
	input  request_t                        request,
	output lane_op_t [NUM_LANES-1:0]        ops_s1
);

	lane_op_t [NUM_LANES-1:0] ops;
	logic [CH_W-1:0] a_ch [NUM_LANES-1];
	logic [CH_W-1:0] b_ch [NUM_LANES-1];
	logic [CH_W-1:0] mix_sat;
	logic [CH_W-1:0] mix_inv;
	logic            b_opaque;
	logic [CH_W-1:0] filt_mag;

	always_comb begin
		a_ch[LANE_RED]   = request.a_red;
		a_ch[LANE_GREEN] = request.a_green;
		a_ch[LANE_BLUE]  = request.a_blue;
		b_ch[LANE_RED]   = request.b_red;
		b_ch[LANE_GREEN] = request.b_green;
		b_ch[LANE_BLUE]  = request.b_blue;
		mix_sat  = (request.mix_amount > ONE) ? ONE : request.mix_amount;
		mix_inv  = ONE - mix_sat;
		b_opaque = (request.b_alpha <= ONE);
		filt_mag = b_opaque ? (ONE - request.b_alpha) : (request.b_alpha - ONE);
	end

	always_comb begin
		ops = '0;
		for (int i = 0; i < NUM_LANES - 1; i++) begin
			case (request.action)
				ACT_AVERAGE: begin
					ops[i].ctl = '{mode: LANE_HALF, clamp: 1'b1};
					ops[i].x0  = a_ch[i];
					ops[i].x1  = b_ch[i];
				end
				ACT_ADD, ACT_MULTIPLY: begin
					ops[i].ctl.mode  = (request.action == ACT_ADD) ? LANE_PSUM : LANE_PPROD;
					ops[i].ctl.clamp = 1'b1;
					ops[i].x0  = a_ch[i];
					ops[i].y0  = request.a_alpha;
					ops[i].x1  = b_ch[i];
					ops[i].y1  = request.b_alpha;
				end
				ACT_FILTER: begin
					ops[i].ctl.mode  = b_opaque ? LANE_FADD : LANE_FSUB;
					ops[i].ctl.clamp = 1'b1;
					ops[i].x0  = filt_mag;
					ops[i].y0  = a_ch[i];
					ops[i].x1  = b_ch[i];
				end
				ACT_MIX: begin
					ops[i].ctl = '{mode: LANE_PSUM, clamp: 1'b0};
					ops[i].x0  = a_ch[i];
					ops[i].y0  = mix_sat;
					ops[i].x1  = b_ch[i];
					ops[i].y1  = mix_inv;
				end
				default: begin
					ops[i].ctl = '{mode: LANE_ZERO, clamp: 1'b0};
				end
			endcase
		end

		ops[LANE_ALPHA].x0 = request.a_alpha;
		case (request.action)
			ACT_AVERAGE: begin
				ops[LANE_ALPHA].ctl = '{mode: LANE_HALF, clamp: 1'b0};
				ops[LANE_ALPHA].x1  = request.b_alpha;
			end
			ACT_ADD, ACT_FILTER: begin
				ops[LANE_ALPHA].ctl = '{mode: LANE_SUM, clamp: 1'b0};
				ops[LANE_ALPHA].x1  = request.b_alpha;
			end
			ACT_MULTIPLY: begin
				ops[LANE_ALPHA].ctl = '{mode: LANE_PSUM, clamp: 1'b0};
				ops[LANE_ALPHA].y0  = request.b_alpha;
			end
			ACT_MIX: begin
				ops[LANE_ALPHA].ctl = '{mode: LANE_PSUM, clamp: 1'b0};
				ops[LANE_ALPHA].y0  = mix_sat;
				ops[LANE_ALPHA].x1  = request.b_alpha;
				ops[LANE_ALPHA].y1  = mix_inv;
			end
			default: begin
				ops[LANE_ALPHA].ctl = '{mode: LANE_ZERO, clamp: 1'b0};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ops_s1 <= ops;
	end

endmodule

// ----- rtl/core/rcb_lane.sv -----
// ----------------------------------------------------------------------------
// RGBA colour blend lane
// Three register stages for one channel: products, combination with a
// second product, then selection, clamping and the output register.
// ----------------------------------------------------------------------------
module rcb_lane import rcb_pkg::*; (
	input  logic               clk,
	input  lane_op_t           op_s1,
	output logic [ALPHA_W-1:0] value_s4
);

	lane_ctl_t         ctl_s2;
	logic [PROD_W-1:0] p0_s2;
	logic [PROD_W-1:0] p1_s2;
	logic [CH_W-1:0]   x1_s2;
	logic [SUM_W-1:0]  sum_s2;

	lane_ctl_t         ctl_s3;
	logic [VAL_W-1:0]  val_s3;
	logic [MUL_W-1:0]  prod_s3;

	logic [SHP_W-1:0]  sh0;
	logic [SHP_W-1:0]  sh1;
	logic [PROD_W:0]   psum;
	logic [VAL_W-1:0]  val;
	logic [VAL_W-1:0]  sel;

	always_ff @(posedge clk) begin
		ctl_s2 <= op_s1.ctl;
		p0_s2  <= PROD_W'(op_s1.x0) * PROD_W'(op_s1.y0);
		p1_s2  <= PROD_W'(op_s1.x1) * PROD_W'(op_s1.y1);
		x1_s2  <= op_s1.x1;
		sum_s2 <= SUM_W'(op_s1.x0) + SUM_W'(op_s1.x1);
	end

	always_comb begin
		sh0  = p0_s2[PROD_W-1:FRAC_BITS];
		sh1  = p1_s2[PROD_W-1:FRAC_BITS];
		psum = (PROD_W+1)'(p0_s2) + (PROD_W+1)'(p1_s2);
		case (ctl_s2.mode)
			LANE_HALF: val = VAL_W'(sum_s2[SUM_W-1:1]);
			LANE_SUM:  val = VAL_W'(sum_s2);
			LANE_PSUM: val = VAL_W'(psum[PROD_W:FRAC_BITS]);
			LANE_FADD: val = VAL_W'(x1_s2) + VAL_W'(sh0);
			LANE_FSUB: val = (sh0 >= SHP_W'(x1_s2)) ? '0 : VAL_W'(x1_s2) - VAL_W'(sh0);
			default:   val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		ctl_s3  <= ctl_s2;
		val_s3  <= val;
		prod_s3 <= MUL_W'(sh0) * MUL_W'(sh1);
	end

	always_comb begin
		sel = (ctl_s3.mode == LANE_PPROD) ? prod_s3[MUL_W-1:FRAC_BITS] : val_s3;
		if (ctl_s3.clamp && (sel > VAL_W'(ONE))) begin
			sel = VAL_W'(ONE);
		end
	end

	always_ff @(posedge clk) begin
		value_s4 <= sel[ALPHA_W-1:0];
	end

endmodule

// ----- rtl/core/rgba_color_blend_unit.sv -----
// ----------------------------------------------------------------------------
// RGBA colour blend unit
// Blends two RGBA colours by average, add, multiply, filter or mix.
// ----------------------------------------------------------------------------
// An accepted item moves through valid_s1 to valid_s4 with its data; done is valid_s4
// and rises with the result in the output register; the receiver cannot stall.
// Throughput: one item per cycle; busy stays low, so start may be high always.
// The four register stages are the operand decode, the first products, the
// second product or combination, and the clamping output register.
// Reset clears the stage valid bits only; items in flight are dropped.
module rgba_color_blend_unit import rcb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	lane_op_t [NUM_LANES-1:0] ops_s1;
	logic [ALPHA_W-1:0]       lane_out [NUM_LANES];
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	logic                     valid_s4;

	assign busy = 1'b0;

	rcb_front u_front (
		.clk     (clk),
		.request (request),
		.ops_s1  (ops_s1)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rcb_lane u_lane (
			.clk      (clk),
			.op_s1    (ops_s1[i]),
			.value_s4 (lane_out[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign done             = valid_s4;
	assign result.out_red   = lane_out[LANE_RED][CH_W-1:0];
	assign result.out_green = lane_out[LANE_GREEN][CH_W-1:0];
	assign result.out_blue  = lane_out[LANE_BLUE][CH_W-1:0];
	assign result.out_alpha = lane_out[LANE_ALPHA];

endmodule

// ----- rtl/core/rcb_checker.sv -----
// ----------------------------------------------------------------------------
// RGBA colour blend checker
// Port-level checks on busy, latency, clamping, the averaged alpha and the unused operation codes.
// ----------------------------------------------------------------------------
module rcb_checker import rcb_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input request_t request,
	input logic     done,
	input result_t  result
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("The unit refused an item.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("An accepted item gave no result after four cycles.");

	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(request.action != ACT_MIX, 4)) |->
		(result.out_red <= ONE && result.out_green <= ONE && result.out_blue <= ONE))
		else $error("A clamped colour channel exceeds one.");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(request.action > ACT_MIX, 4)) |-> (result == '0))
		else $error("An unused operation code gave a non-zero result.");

	a_avg_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(request.action == ACT_AVERAGE, 4)) |->
		(result.out_alpha == ALPHA_W'((($past({1'b0, request.a_alpha}, 4)
			+ $past({1'b0, request.b_alpha}, 4)) >> 1))))
		else $error("The averaged alpha is wrong.");

endmodule

bind rgba_color_blend_unit rcb_checker u_checker (.*);

// ----- dv/rcb_blend_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBA colour blend checker
// Watches the item and result channels of the blend unit, predicts each
// blended colour from the accepted item and compares the results in order.
// ----------------------------------------------------------------------------
module rcb_blend_checker import rcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  request_t    request,
	input  logic        done,
	input  result_t     result,
	output int unsigned fail_count,
	output int unsigned pending
);

	result_t     expected_colours[$];
	int unsigned errors = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [63:0] sat_one(logic [63:0] v);
		return (v > 64'(ONE)) ? 64'(ONE) : v;
	endfunction

	function automatic logic [CH_W-1:0] blend_colour(logic [ACT_W-1:0] act,
			logic [63:0] ac, logic [63:0] aa, logic [63:0] bc,
			logic [63:0] ba, logic [63:0] m);
		logic [63:0] one_v;
		logic [63:0] wa;
		logic [63:0] wb;
		logic [63:0] term;
		logic [63:0] v;
		one_v = 64'(ONE);
		v     = '0;
		case (act)
			ACT_AVERAGE: begin
				v = sat_one((ac + bc) >> 1);
			end
			ACT_ADD: begin
				v = sat_one((ac * aa + bc * ba) >> FRAC_BITS);
			end
			ACT_MULTIPLY: begin
				wa = (ac * aa) >> FRAC_BITS;
				wb = (bc * ba) >> FRAC_BITS;
				v  = sat_one((wa * wb) >> FRAC_BITS);
			end
			ACT_FILTER: begin
				if (ba <= one_v) begin
					term = ((one_v - ba) * ac) >> FRAC_BITS;
					v    = sat_one(bc + term);
				end else begin
					term = ((ba - one_v) * ac) >> FRAC_BITS;
					v    = (term >= bc) ? '0 : sat_one(bc - term);
				end
			end
			ACT_MIX: begin
				v = (ac * m + bc * (one_v - m)) >> FRAC_BITS;
			end
			default: begin
				v = '0;
			end
		endcase
		return v[CH_W-1:0];
	endfunction

	function automatic logic [ALPHA_W-1:0] blend_opacity(logic [ACT_W-1:0] act,
			logic [63:0] aa, logic [63:0] ba, logic [63:0] m);
		logic [63:0] v;
		v = '0;
		case (act)
			ACT_AVERAGE:           v = (aa + ba) >> 1;
			ACT_ADD, ACT_FILTER:   v = aa + ba;
			ACT_MULTIPLY:          v = (aa * ba) >> FRAC_BITS;
			ACT_MIX:               v = (aa * m + ba * (64'(ONE) - m)) >> FRAC_BITS;
			default:               v = '0;
		endcase
		return v[ALPHA_W-1:0];
	endfunction

	function automatic result_t predict_blend(request_t r);
		result_t     c;
		logic [63:0] m;
		m           = sat_one(64'(r.mix_amount));
		c.out_red   = blend_colour(r.action, r.a_red, r.a_alpha, r.b_red, r.b_alpha, m);
		c.out_green = blend_colour(r.action, r.a_green, r.a_alpha, r.b_green, r.b_alpha, m);
		c.out_blue  = blend_colour(r.action, r.a_blue, r.a_alpha, r.b_blue, r.b_alpha, m);
		c.out_alpha = blend_opacity(r.action, r.a_alpha, r.b_alpha, m);
		return c;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_colours.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, result);
				end else begin
					want = expected_colours.pop_front();
					check_field("out_red", want.out_red, result.out_red);
					check_field("out_green", want.out_green, result.out_green);
					check_field("out_blue", want.out_blue, result.out_blue);
					check_field("out_alpha", want.out_alpha, result.out_alpha);
				end
			end
			if (start && !busy)
				expected_colours.push_back(predict_blend(request));
		end
		fail_count <= errors;
		pending    <= expected_colours.size();
	end

endmodule

// ----- dv/tb_rgba_color_blend_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBA colour blend unit testbench
// Sends directed corner items and then random colour pairs with random
// gaps to the blend unit; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rgba_color_blend_unit;
	import rcb_pkg::*;

	localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = 3'd5;
	localparam logic [ACT_W-1:0] ACT_LAST_CODE    = 3'd7;
	localparam logic [CH_W-1:0]  CH_MAX           = '1;
	localparam int               NUM_RANDOM       = 1300;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	request_t    request;
	result_t     result;
	int unsigned fail_count;
	int unsigned pending;

	rgba_color_blend_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	rcb_blend_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic request_t make_request(logic [ACT_W-1:0] act,
			logic [CH_W-1:0] a_c, logic [CH_W-1:0] a_al,
			logic [CH_W-1:0] b_c, logic [CH_W-1:0] b_al, logic [CH_W-1:0] mix);
		request_t r;
		r.action     = act;
		r.a_red      = a_c;
		r.a_green    = a_c;
		r.a_blue     = a_c;
		r.a_alpha    = a_al;
		r.b_red      = b_c;
		r.b_green    = b_c;
		r.b_blue     = b_c;
		r.b_alpha    = b_al;
		r.mix_amount = mix;
		return r;
	endfunction

	function automatic logic [CH_W-1:0] random_level();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return '0;
		if (pick < 10)
			return ONE;
		if (pick < 75)
			return CH_W'($urandom_range(0, 256));
		return CH_W'($urandom_range(0, 511));
	endfunction

	function automatic request_t random_request();
		request_t r;
		if ($urandom_range(0, 99) < 90)
			r.action = ACT_W'($urandom_range(ACT_AVERAGE, ACT_MIX));
		else
			r.action = ACT_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
		r.a_red      = random_level();
		r.a_green    = random_level();
		r.a_blue     = random_level();
		r.a_alpha    = random_level();
		r.b_red      = random_level();
		r.b_green    = random_level();
		r.b_blue     = random_level();
		r.b_alpha    = random_level();
		r.mix_amount = random_level();
		return r;
	endfunction

	task automatic send_item(request_t r, int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic int unsigned random_gap(int unsigned idx);
		int unsigned pick;
		if (idx % 200 < 40)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		request_t    items[$];
		logic [ACT_W-1:0] act;
		start   <= 1'b0;
		request <= '0;
		arst_n  <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Each operation at full scale, with every field at its maximum, and
		// with a saturated first colour against a black second colour.
		for (int op = ACT_AVERAGE; op <= ACT_MIX; op++) begin
			act = ACT_W'(op);
			items.push_back(make_request(act, ONE, ONE, ONE, ONE, ONE));
			items.push_back(make_request(act, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX));
			items.push_back(make_request(act, CH_MAX, CH_MAX, '0, '0, '0));
		end
		// Filter with opacity above one: the subtracted term both exceeds
		// and stays below the second colour.
		items.push_back(make_request(ACT_FILTER, CH_MAX, ONE, 9'd20, 9'd300, '0));
		items.push_back(make_request(ACT_FILTER, CH_MAX, ONE, 9'd200, 9'd300, '0));
		for (int op = ACT_FIRST_UNUSED; op <= ACT_LAST_CODE; op++)
			items.push_back(make_request(ACT_W'(op), CH_MAX, CH_MAX, CH_MAX, CH_MAX,
				CH_MAX));

		foreach (items[i])
			send_item(items[i], (i % 4 == 3) ? 2 : 0);
		drain_results();

		for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM / 2)
				drain_results();
			send_item(random_request(), random_gap(i));
		end
		drain_results();
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
